/* rtl/lupc_pkg.sv */
// Shared types and constants for the latch unlock pulse controller.
`timescale 1ns / 1ps
`default_nettype none

package lupc_pkg;

    localparam int TIME_MAX_WIDTH = 32;
    localparam int IN_DATA_WIDTH  = 104;
    localparam int OUT_DATA_WIDTH = 56;

    localparam logic [15:0] UNLOCK_DELAY_RESET = 16'd0;
    localparam logic [15:0] DELAY_MAX_RESET    = 16'd60000;
    localparam logic [15:0] PULSE_CAP_RESET    = 16'd500;
    localparam logic [15:0] COOLDOWN_RESET     = 16'd2000;

    // x / 1000 == (x * DIV_RECIP) >> DIV_SHIFT for every 32-bit x
    localparam int          MS_PER_SECOND = 1000;
    localparam int          DIV_SHIFT     = 38;
    localparam int          PRODUCT_WIDTH = 61;
    localparam logic [28:0] DIV_RECIP     = 29'd274877907;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DELAY    = 2'd1,
        PH_PULSE    = 2'd2,
        PH_COOLDOWN = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        REG_UNLOCK_DELAY = 2'd0,
        REG_DELAY_MAX    = 2'd1,
        REG_PULSE_CAP    = 2'd2,
        REG_COOLDOWN     = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [15:0] unlock_delay_ms;
        logic [15:0] delay_limit_ms;
        logic [15:0] pulse_cap_ms;
        logic [15:0] cooldown_ms;
    } cfg_t;

    typedef struct packed {
        logic        op;
        logic [31:0] now_ms;
        logic        sense_low;
        logic [15:0] pulse_ms;
        logic [15:0] requester_id;
        logic [15:0] enable_id;
        logic        ignore_sense;
        logic [15:0] active_enable_id;
    } item_t;

    typedef struct packed {
        logic                      accepted;
        logic                      busy_with_same;
        phase_t                    phase;
        logic                      locked;
        logic                      clear_valid;
        logic [15:0]               clear_id;
        logic                      enable_valid;
        logic [15:0]               enable_set_id;
        logic                      is_tick;
        logic [TIME_MAX_WIDTH-1:0] elapsed;
    } stage_t;

    typedef struct packed {
        logic        accepted;
        logic        busy_with_same;
        logic        drive_on;
        phase_t      phase;
        logic        locked;
        logic [15:0] seconds_unlocked;
        logic        clear_valid;
        logic [15:0] clear_id;
        logic        enable_valid;
        logic [15:0] enable_set_id;
    } result_t;

endpackage

`default_nettype wire

/* rtl/lupc_seq.sv */
// Unlock sequencer state, debounce and time-since-locked capture for one item.
`timescale 1ns / 1ps
`default_nettype none

module lupc_seq #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             take,
    input  wire lupc_pkg::item_t  item,
    input  wire lupc_pkg::cfg_t   cfg,
    output lupc_pkg::stage_t      stage,
    output lupc_pkg::phase_t      phase
);

    localparam int EW = lupc_pkg::TIME_MAX_WIDTH;

    lupc_pkg::phase_t        phase_reg, phase_next;
    logic [TIME_WIDTH-1:0]   delay_start_reg, delay_start_next;
    logic [TIME_WIDTH-1:0]   pulse_start_reg, pulse_start_next;
    logic [15:0]             delay_cap_reg, delay_cap_next;
    logic [15:0]             min_pulse_reg, min_pulse_next;
    logic [15:0]             pend_req_reg, pend_req_next;
    logic [15:0]             pend_en_reg, pend_en_next;
    logic                    pend_ign_reg, pend_ign_next;
    logic                    lock_reg, lock_next;
    logic                    prev_reg, prev_next;
    logic [TIME_WIDTH-1:0]   last_locked_reg, last_locked_next;

    logic [TIME_WIDTH-1:0]   now_t;
    logic [TIME_WIDTH-1:0]   el_delay;
    logic [TIME_WIDTH-1:0]   el_pulse;
    logic [TIME_WIDTH-1:0]   el_lock;
    logic                    finish;

    assign now_t    = item.now_ms[TIME_WIDTH-1:0];
    assign el_delay = now_t - delay_start_reg;
    assign el_pulse = now_t - pulse_start_reg;
    assign el_lock  = now_t - last_locked_reg;
    assign phase    = phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= lupc_pkg::PH_IDLE;
            delay_start_reg <= '0;
            pulse_start_reg <= '0;
            delay_cap_reg   <= '0;
            min_pulse_reg   <= '0;
            pend_req_reg    <= '0;
            pend_en_reg     <= '0;
            pend_ign_reg    <= 1'b0;
            lock_reg        <= 1'b0;
            prev_reg        <= 1'b0;
            last_locked_reg <= '0;
        end
        else if (take)
        begin
            phase_reg       <= phase_next;
            delay_start_reg <= delay_start_next;
            pulse_start_reg <= pulse_start_next;
            delay_cap_reg   <= delay_cap_next;
            min_pulse_reg   <= min_pulse_next;
            pend_req_reg    <= pend_req_next;
            pend_en_reg     <= pend_en_next;
            pend_ign_reg    <= pend_ign_next;
            lock_reg        <= lock_next;
            prev_reg        <= prev_next;
            last_locked_reg <= last_locked_next;
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        delay_start_next = delay_start_reg;
        pulse_start_next = pulse_start_reg;
        delay_cap_next   = delay_cap_reg;
        min_pulse_next   = min_pulse_reg;
        pend_req_next    = pend_req_reg;
        pend_en_next     = pend_en_reg;
        pend_ign_next    = pend_ign_reg;
        lock_next        = lock_reg;
        prev_next        = prev_reg;
        last_locked_next = last_locked_reg;
        finish           = 1'b0;

        stage                = '0;
        stage.busy_with_same = (phase_reg != lupc_pkg::PH_IDLE)
                               && (pend_req_reg == item.requester_id);

        if (item.op)
        begin
            if (phase_reg == lupc_pkg::PH_IDLE)
            begin
                delay_cap_next = (cfg.unlock_delay_ms > cfg.delay_limit_ms)
                                 ? cfg.delay_limit_ms : cfg.unlock_delay_ms;
                min_pulse_next = (item.pulse_ms > cfg.pulse_cap_ms)
                                 ? cfg.pulse_cap_ms : item.pulse_ms;
                pend_req_next    = item.requester_id;
                pend_en_next     = item.enable_id;
                pend_ign_next    = item.ignore_sense;
                delay_start_next = now_t;
                phase_next       = lupc_pkg::PH_DELAY;
                stage.accepted   = 1'b1;
            end
        end
        else
        begin
            unique case (phase_reg)
                lupc_pkg::PH_IDLE:
                begin
                end
                lupc_pkg::PH_DELAY:
                begin
                    if (el_delay >= TIME_WIDTH'(delay_cap_reg))
                    begin
                        if (pend_ign_reg || item.sense_low)
                        begin
                            pulse_start_next = now_t;
                            phase_next       = lupc_pkg::PH_PULSE;
                        end
                        else
                        begin
                            finish     = 1'b1;
                            phase_next = lupc_pkg::PH_IDLE;
                        end
                    end
                end
                lupc_pkg::PH_PULSE:
                begin
                    if ((el_pulse >= TIME_WIDTH'(cfg.pulse_cap_ms))
                        || (!pend_ign_reg && (el_pulse >= TIME_WIDTH'(min_pulse_reg))
                            && !item.sense_low))
                    begin
                        finish     = 1'b1;
                        phase_next = lupc_pkg::PH_COOLDOWN;
                    end
                end
                lupc_pkg::PH_COOLDOWN:
                begin
                    if (el_pulse >= TIME_WIDTH'(cfg.cooldown_ms))
                        phase_next = lupc_pkg::PH_IDLE;
                end
                default:
                begin
                end
            endcase

            if (finish)
            begin
                if (pend_req_reg != 16'd0)
                begin
                    stage.clear_valid = 1'b1;
                    stage.clear_id    = pend_req_reg;
                end
                if ((pend_en_reg != 16'd0) && (pend_en_reg == item.active_enable_id))
                begin
                    stage.enable_valid  = 1'b1;
                    stage.enable_set_id = pend_en_reg;
                end
                pend_req_next = '0;
                pend_en_next  = '0;
            end

            lock_next = item.sense_low && prev_reg;
            prev_next = item.sense_low;
            if (lock_next)
                last_locked_next = now_t;
        end

        stage.phase   = phase_next;
        stage.locked  = lock_next;
        stage.is_tick = !item.op;
        stage.elapsed = EW'(el_lock);
    end

endmodule

`default_nettype wire

/* rtl/lupc_secs.sv */
// Seconds-unlocked divide by reciprocal and result register.
`timescale 1ns / 1ps
`default_nettype none

module lupc_secs (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire lupc_pkg::stage_t  stage,
    output lupc_pkg::result_t      result
);

    localparam int PW = lupc_pkg::PRODUCT_WIDTH;
    localparam int QL = lupc_pkg::DIV_SHIFT;

    logic [PW-1:0]       product;
    logic [15:0]         seconds;
    logic [15:0]         held_seconds_reg, held_seconds_next;
    lupc_pkg::result_t   result_reg, result_next;

    assign product = PW'(stage.elapsed) * PW'(lupc_pkg::DIV_RECIP);
    assign seconds = product[QL+15:QL];

    always_comb
    begin
        if (!stage.is_tick)
            held_seconds_next = held_seconds_reg;
        else if (stage.locked)
            held_seconds_next = '0;
        else
            held_seconds_next = seconds;

        result_next.accepted         = stage.accepted;
        result_next.busy_with_same   = stage.busy_with_same;
        result_next.drive_on         = (stage.phase == lupc_pkg::PH_PULSE);
        result_next.phase            = stage.phase;
        result_next.locked           = stage.locked;
        result_next.seconds_unlocked = held_seconds_next;
        result_next.clear_valid      = stage.clear_valid;
        result_next.clear_id         = stage.clear_id;
        result_next.enable_valid     = stage.enable_valid;
        result_next.enable_set_id    = stage.enable_set_id;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_seconds_reg <= '0;
        else if (load)
            held_seconds_reg <= held_seconds_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

`default_nettype wire

/* rtl/latch_unlock_pulse_controller.sv */
// Latch unlock pulse controller top level: config registers, pipeline and stream ports.
//
// Usage: each item on the s_axis channel is either a tick (tuser 0) carrying the
// millisecond time, the sense sample and the active enable id, or an unlock request
// (tuser 1) carrying time, pulse length, requester id, enable id and ignore-sense.
// Every accepted item yields exactly one result item on m_axis, in order.
// Registers are written through cfg_we / cfg_addr / cfg_wdata, one per cycle, and
// take effect for items accepted after the write.
// The sequencer state and the stage register load at the accepting edge; the seconds
// divide feeds the result register, which loads when it is empty or being taken.
// Throughput is one item per cycle, sustained while m_axis_tready stays high.
// When m_axis_tready is low the result register holds, the stage behind it fills,
// and s_axis_tready then drops until the receiver takes a result.
// Reset clears both stage valids, the sequencer to idle with zeroed captures, the
// debounce and time-since-locked state, and loads the register defaults
// (delay 0, delay max 60000, pulse cap 500, cooldown 2000).
`timescale 1ns / 1ps
`default_nettype none

module latch_unlock_pulse_controller #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // now_ms[31:0], sense_low[32], pulse_ms[48:33], requester_id[64:49],
    // enable_id[80:65], ignore_sense[81], active_enable_id[97:82], zero pad
    input  wire logic [lupc_pkg::IN_DATA_WIDTH-1:0]  s_axis_tdata,
    // op[0]
    input  wire logic        s_axis_tuser,
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // accepted[0], busy_with_same[1], drive_on[2], phase[4:3], locked[5],
    // seconds_unlocked[21:6], clear_valid[22], clear_id[38:23],
    // enable_valid[39], enable_set_id[55:40]
    output      logic [lupc_pkg::OUT_DATA_WIDTH-1:0] m_axis_tdata
);

    lupc_pkg::cfg_t     cfg_reg;
    lupc_pkg::item_t    item;
    lupc_pkg::stage_t   stage_comb;
    lupc_pkg::stage_t   stage_reg;
    lupc_pkg::result_t  result;
    lupc_pkg::phase_t   seq_phase;

    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic advance;
    logic load;
    logic take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unlock_delay_ms <= lupc_pkg::UNLOCK_DELAY_RESET;
            cfg_reg.delay_limit_ms  <= lupc_pkg::DELAY_MAX_RESET;
            cfg_reg.pulse_cap_ms    <= lupc_pkg::PULSE_CAP_RESET;
            cfg_reg.cooldown_ms     <= lupc_pkg::COOLDOWN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (lupc_pkg::reg_index_t'(cfg_addr))
                lupc_pkg::REG_UNLOCK_DELAY: cfg_reg.unlock_delay_ms <= cfg_wdata;
                lupc_pkg::REG_DELAY_MAX:    cfg_reg.delay_limit_ms  <= cfg_wdata;
                lupc_pkg::REG_PULSE_CAP:    cfg_reg.pulse_cap_ms    <= cfg_wdata;
                lupc_pkg::REG_COOLDOWN:     cfg_reg.cooldown_ms     <= cfg_wdata;
                default:                    cfg_reg.cooldown_ms     <= cfg_reg.cooldown_ms;
            endcase
        end
    end

    assign item.op               = s_axis_tuser;
    assign item.now_ms           = s_axis_tdata[31:0];
    assign item.sense_low        = s_axis_tdata[32];
    assign item.pulse_ms         = s_axis_tdata[48:33];
    assign item.requester_id     = s_axis_tdata[64:49];
    assign item.enable_id        = s_axis_tdata[80:65];
    assign item.ignore_sense     = s_axis_tdata[81];
    assign item.active_enable_id = s_axis_tdata[97:82];

    // advance the result register when it is empty or being taken
    assign advance        = !out_valid_reg || m_axis_tready;
    assign load           = s1_valid_reg && advance;
    assign s_axis_tready  = !s1_valid_reg || advance;
    assign take           = s_axis_tvalid && s_axis_tready;
    assign s1_valid_next  = take || (s1_valid_reg && !advance);
    assign out_valid_next = load || (out_valid_reg && !m_axis_tready);

    lupc_seq #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (item),
        .cfg   (cfg_reg),
        .stage (stage_comb),
        .phase (seq_phase)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            stage_reg <= stage_comb;
    end

    lupc_secs u_secs (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .stage  (stage_reg),
        .result (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {result.enable_set_id, result.enable_valid,
                            result.clear_id, result.clear_valid,
                            result.seconds_unlocked, result.locked,
                            result.phase, result.drive_on,
                            result.busy_with_same, result.accepted};

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while both stages are stalled");

    a_accept_enters_delay: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result.accepted) |-> (result.phase == lupc_pkg::PH_DELAY))
        else $error("accepted request did not enter the delay phase");

    a_finish_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (result.clear_valid || result.enable_valid))
        |-> ((result.phase == lupc_pkg::PH_COOLDOWN) || (result.phase == lupc_pkg::PH_IDLE)))
        else $error("finish report outside a finishing transition");

    a_phase_moves_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(seq_phase))
        else $error("sequencer phase changed without an accepted item");
`endif

endmodule

`default_nettype wire

/* sim/tb_latch_unlock_pulse_controller.sv */
// Self-checking testbench for the latch unlock pulse controller stream block.
`timescale 1ns / 1ps

module tb_latch_unlock_pulse_controller;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;
    localparam int   ITEMS_PER_SETTING = 280;
    localparam int   HOLD_CYCLES       = 80;
    localparam int   HOLD_AFTER        = 500;
    localparam int   NUM_SETTINGS      = 5;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [lupc_pkg::IN_DATA_WIDTH-1:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [lupc_pkg::OUT_DATA_WIDTH-1:0] m_axis_tdata;

    latch_unlock_pulse_controller DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // sequencer prediction state
    lupc_pkg::cfg_t   regs = '{lupc_pkg::UNLOCK_DELAY_RESET, lupc_pkg::DELAY_MAX_RESET,
                               lupc_pkg::PULSE_CAP_RESET, lupc_pkg::COOLDOWN_RESET};
    lupc_pkg::phase_t seq_phase = lupc_pkg::PH_IDLE;
    logic [31:0] delay_t0 = '0;
    logic [31:0] pulse_t0 = '0;
    logic [15:0] held_delay = '0;
    logic [15:0] held_min_pulse = '0;
    logic [15:0] pend_req = '0;
    logic [15:0] pend_en = '0;
    logic        pend_ign = 1'b0;
    logic        lock_db = 1'b0;
    logic        last_sense = 1'b0;
    logic [31:0] locked_at = '0;
    logic [15:0] secs_held = '0;

    lupc_pkg::item_t   queued_items[$];
    lupc_pkg::result_t expected_outcomes[$];
    int      items_queued = 0;
    int      items_taken = 0;
    bit      failed = 1'b0;

    lupc_pkg::item_t   offered;
    lupc_pkg::result_t outcome;
    lupc_pkg::result_t want;
    int      burst_left = 0;
    int      gap_left = 0;
    logic    long_hold = 1'b0;
    int      hold_left = 0;
    bit      hold_used = 1'b0;
    int      rx_count = 0;
    int      rx_span = 0;
    int      rx_mode = 0;

    logic [31:0] gen_time = '0;
    logic        gen_sense = 1'b0;
    logic [15:0] gen_last_req = '0;
    logic [15:0] gen_last_en = '0;

    function automatic lupc_pkg::result_t advance_sequencer(lupc_pkg::item_t it);
        lupc_pkg::result_t r;
        logic    finish;
        logic [31:0] el;
        r = '0;
        finish = 1'b0;
        r.busy_with_same = (seq_phase != lupc_pkg::PH_IDLE) && (pend_req == it.requester_id);
        if (it.op == OP_REQUEST) begin
            if (seq_phase == lupc_pkg::PH_IDLE) begin
                held_delay = (regs.unlock_delay_ms > regs.delay_limit_ms) ?
                             regs.delay_limit_ms : regs.unlock_delay_ms;
                held_min_pulse = (it.pulse_ms > regs.pulse_cap_ms) ? regs.pulse_cap_ms
                                                                    : it.pulse_ms;
                pend_req = it.requester_id;
                pend_en = it.enable_id;
                pend_ign = it.ignore_sense;
                delay_t0 = it.now_ms;
                seq_phase = lupc_pkg::PH_DELAY;
                r.accepted = 1'b1;
            end
        end
        else begin
            case (seq_phase)
                lupc_pkg::PH_DELAY:
                begin
                    el = it.now_ms - delay_t0;
                    if (el >= held_delay) begin
                        if (pend_ign || it.sense_low) begin
                            pulse_t0 = it.now_ms;
                            seq_phase = lupc_pkg::PH_PULSE;
                        end
                        else begin
                            finish = 1'b1;
                            seq_phase = lupc_pkg::PH_IDLE;
                        end
                    end
                end
                lupc_pkg::PH_PULSE:
                begin
                    el = it.now_ms - pulse_t0;
                    if (el >= regs.pulse_cap_ms ||
                        (!pend_ign && el >= held_min_pulse && !it.sense_low)) begin
                        finish = 1'b1;
                        seq_phase = lupc_pkg::PH_COOLDOWN;
                    end
                end
                lupc_pkg::PH_COOLDOWN:
                begin
                    el = it.now_ms - pulse_t0;
                    if (el >= regs.cooldown_ms) seq_phase = lupc_pkg::PH_IDLE;
                end
                default:
                begin
                end
            endcase
            if (finish) begin
                if (pend_req != 0) begin
                    r.clear_valid = 1'b1;
                    r.clear_id = pend_req;
                end
                if (pend_en != 0 && pend_en == it.active_enable_id) begin
                    r.enable_valid = 1'b1;
                    r.enable_set_id = pend_en;
                end
                pend_req = '0;
                pend_en = '0;
            end
            lock_db = it.sense_low && last_sense;
            last_sense = it.sense_low;
            if (lock_db) begin
                locked_at = it.now_ms;
                secs_held = '0;
            end
            else begin
                el = (it.now_ms - locked_at) / lupc_pkg::MS_PER_SECOND;
                secs_held = el[15:0];
            end
        end
        r.drive_on = (seq_phase == lupc_pkg::PH_PULSE);
        r.phase = seq_phase;
        r.locked = lock_db;
        r.seconds_unlocked = secs_held;
        return r;
    endfunction

    function automatic logic [lupc_pkg::IN_DATA_WIDTH-1:0] pack_item(lupc_pkg::item_t it);
        return {6'b0, it.active_enable_id, it.ignore_sense, it.enable_id, it.requester_id,
                it.pulse_ms, it.sense_low, it.now_ms};
    endfunction

    task automatic compare_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            failed = 1'b1;
        end
    endtask

    task automatic check_result(lupc_pkg::result_t e,
                                logic [lupc_pkg::OUT_DATA_WIDTH-1:0] d);
        compare_field("accepted", e.accepted, d[0]);
        compare_field("busy_with_same", e.busy_with_same, d[1]);
        compare_field("drive_on", e.drive_on, d[2]);
        compare_field("phase", e.phase, d[4:3]);
        compare_field("locked", e.locked, d[5]);
        compare_field("seconds_unlocked", e.seconds_unlocked, d[21:6]);
        compare_field("clear_valid", e.clear_valid, d[22]);
        compare_field("clear_id", e.clear_id, d[38:23]);
        compare_field("enable_valid", e.enable_valid, d[39]);
        compare_field("enable_set_id", e.enable_set_id, d[55:40]);
    endtask

    task automatic add_item(logic op, logic [31:0] now, logic sense, logic [15:0] pulse,
                            logic [15:0] req, logic [15:0] en, logic ign, logic [15:0] act);
        lupc_pkg::item_t it;
        it.op = op;
        it.now_ms = now;
        it.sense_low = sense;
        it.pulse_ms = pulse;
        it.requester_id = req;
        it.enable_id = en;
        it.ignore_sense = ign;
        it.active_enable_id = act;
        queued_items.push_back(it);
        items_queued++;
    endtask

    task automatic gen_traffic(int n);
        lupc_pkg::item_t it;
        int unsigned     r;
        for (int i = 0; i < n; i++) begin
            it.pulse_ms = 16'($urandom);
            it.requester_id = 16'($urandom);
            it.enable_id = 16'($urandom);
            it.ignore_sense = 1'($urandom_range(0, 1));
            it.active_enable_id = 16'($urandom);
            r = $urandom_range(0, 99);
            if (r < 70) gen_time += $urandom_range(1, 8);
            else if (r < 90) gen_time += $urandom_range(0, 300);
            else if (r < 98) gen_time += $urandom_range(0, 70000);
            else gen_time = $urandom;
            if ($urandom_range(0, 5) == 0) gen_sense = ~gen_sense;
            it.now_ms = gen_time;
            it.sense_low = gen_sense;
            if ($urandom_range(0, 9) == 0) begin
                it.op = OP_REQUEST;
                r = $urandom_range(0, 9);
                if (r < 6) it.pulse_ms = 16'($urandom_range(0, 40));
                else if (r < 8) it.pulse_ms = 16'($urandom_range(0, 600));
                else if (r < 9) it.pulse_ms = 16'hFFFF;
                r = $urandom_range(0, 19);
                if (r < 3) it.requester_id = '0;
                else if (r < 10) it.requester_id = gen_last_req;
                if ($urandom_range(0, 3) == 0) it.enable_id = '0;
                it.ignore_sense = ($urandom_range(0, 9) < 3);
                if ($urandom_range(0, 9) == 0) it.now_ms = $urandom;
                gen_last_req = it.requester_id;
                gen_last_en = it.enable_id;
            end
            else begin
                it.op = OP_TICK;
                r = $urandom_range(0, 9);
                if (r < 5) it.active_enable_id = gen_last_en;
                else if (r < 6) it.active_enable_id = '0;
            end
            queued_items.push_back(it);
            items_queued++;
        end
    endtask

    task automatic write_reg(lupc_pkg::reg_index_t idx, logic [15:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        case (idx)
            lupc_pkg::REG_UNLOCK_DELAY: regs.unlock_delay_ms = v;
            lupc_pkg::REG_DELAY_MAX:    regs.delay_limit_ms = v;
            lupc_pkg::REG_PULSE_CAP:    regs.pulse_cap_ms = v;
            lupc_pkg::REG_COOLDOWN:     regs.cooldown_ms = v;
            default:                    regs = regs;
        endcase
    endtask

    task automatic wait_drained();
        while (items_taken != items_queued || expected_outcomes.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // sender: bursts of random length with random gaps, no gaps during the long hold
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                outcome = advance_sequencer(offered);
                expected_outcomes.push_back(outcome);
                items_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0 && !long_hold) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (queued_items.size() > 0) begin
                    offered = queued_items.pop_front();
                    s_axis_tdata <= pack_item(offered);
                    s_axis_tuser <= offered.op;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end
                    else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern in spans, one long hold-off to back up the input
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) rx_count++;
            if (hold_left > 0) begin
                hold_left--;
                long_hold <= (hold_left > 0);
                m_axis_tready <= (hold_left == 0);
            end
            else if (!hold_used && rx_count >= HOLD_AFTER) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
                long_hold <= 1'b1;
                m_axis_tready <= 1'b0;
            end
            else begin
                if (rx_span == 0) begin
                    rx_span = $urandom_range(16, 96);
                    rx_mode = $urandom_range(0, 2);
                end
                rx_span--;
                case (rx_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_outcomes.size() == 0) begin
                $error("result with no item outstanding: %h", m_axis_tdata);
                failed = 1'b1;
            end
            else begin
                want = expected_outcomes.pop_front();
                check_result(want, m_axis_tdata);
            end
        end
    end

    logic [15:0] set_delay[NUM_SETTINGS] = '{16'd5, 16'd30, 16'd0, 16'hFFFF, 16'd200};
    logic [15:0] set_max[NUM_SETTINGS]   = '{16'd60000, 16'd12, 16'd0, 16'hFFFF, 16'd150};
    logic [15:0] set_cap[NUM_SETTINGS]   = '{16'd20, 16'd0, 16'd1, 16'hFFFF, 16'd300};
    logic [15:0] set_cool[NUM_SETTINGS]  = '{16'd40, 16'd0, 16'd3, 16'hFFFF, 16'd1000};

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: delay 0, max 60000, cap 500, cooldown 2000
        add_item(OP_TICK, 32'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0);
        add_item(OP_TICK, 32'd1000, 1'b1, 16'd0, 16'd0, 16'd0, 1'b0, 16'hFFFF);
        add_item(OP_TICK, 32'd1001, 1'b1, 16'd0, 16'd0, 16'd0, 1'b0, 16'hFFFF);
        add_item(OP_REQUEST, 32'd1002, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0);
        add_item(OP_REQUEST, 32'd1003, 1'b0, 16'd5, 16'hFFFF, 16'd7, 1'b1, 16'd0);
        add_item(OP_TICK, 32'd1003, 1'b1, 16'd0, 16'd0, 16'd0, 1'b0, 16'hFFFF);
        add_item(OP_TICK, 32'd1300, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 16'hFFFF);
        add_item(OP_TICK, 32'd1503, 1'b1, 16'd0, 16'd0, 16'd0, 1'b0, 16'hFFFF);
        add_item(OP_REQUEST, 32'd1504, 1'b0, 16'd1, 16'd0, 16'd1, 1'b0, 16'd0);
        add_item(OP_TICK, 32'd3003, 1'b1, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0);
        add_item(OP_REQUEST, 32'd3004, 1'b0, 16'd10, 16'd1, 16'd5, 1'b1, 16'd0);
        add_item(OP_TICK, 32'd3005, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd6);
        add_item(OP_TICK, 32'd3504, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd6);
        add_item(OP_TICK, 32'd3505, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd6);
        add_item(OP_TICK, 32'd5505, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0);
        add_item(OP_REQUEST, 32'd5506, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0);
        add_item(OP_TICK, 32'd5507, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0);
        add_item(OP_REQUEST, 32'hFFFF_FFF0, 1'b0, 16'd20, 16'd2, 16'd2, 1'b0, 16'd0);
        add_item(OP_TICK, 32'hFFFF_FFFF, 1'b1, 16'd0, 16'd0, 16'd0, 1'b0, 16'd2);
        add_item(OP_TICK, 32'h0000_0010, 1'b1, 16'd0, 16'd0, 16'd0, 1'b0, 16'd2);
        add_item(OP_TICK, 32'h0000_0020, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd2);
        add_item(OP_TICK, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF);
        add_item(OP_REQUEST, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
                 16'hFFFF);
        add_item(OP_TICK, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF);
        add_item(OP_TICK, 32'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0);
        gen_traffic(ITEMS_PER_SETTING);

        for (int p = 0; p < NUM_SETTINGS; p++) begin
            wait_drained();
            write_reg(lupc_pkg::REG_UNLOCK_DELAY, set_delay[p]);
            write_reg(lupc_pkg::REG_DELAY_MAX, set_max[p]);
            write_reg(lupc_pkg::REG_PULSE_CAP, set_cap[p]);
            write_reg(lupc_pkg::REG_COOLDOWN, set_cool[p]);
            @(posedge clk);
            cfg_we <= 1'b0;
            gen_traffic(ITEMS_PER_SETTING);
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (expected_outcomes.size() != 0) begin
            $error("%0d results never arrived", expected_outcomes.size());
            failed = 1'b1;
        end
        if (!failed) begin
            $display("PASS");
        end
        else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/lupc_pkg.sv
rtl/lupc_seq.sv
rtl/lupc_secs.sv
rtl/latch_unlock_pulse_controller.sv
sim/tb_latch_unlock_pulse_controller.sv
